// ===== design/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256 engine package
// Round constants, initial hash values, padding constants, the queue entry type and round helper functions.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int unsigned NumRounds = 64;

  typedef logic [31:0] word_t;

  // Front-to-back queue entry
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
  } cmd_t;

  localparam word_t InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenOffset = 6'd56;

  function automatic word_t ror(input word_t x, input int unsigned n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t sig0(input word_t x);
    sig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t sig1(input word_t x);
    sig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t bsig0(input word_t x);
    bsig0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic word_t bsig1(input word_t x);
    bsig1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

endpackage

// ===== design/sha_queue.sv =====
// ----------------------------------------------------------------------------
// SHA command queue
// Small register FIFO between the byte front end and the hash back end.
// ----------------------------------------------------------------------------
module sha_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sha_pkg::cmd_t wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output sha_pkg::cmd_t rdata_o,
  output logic          empty_o
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  sha_pkg::cmd_t     mem_q [Depth];
  logic [AW-1:0]     wr_q, rd_q;
  logic [AW:0]       cnt_q;

  logic do_push, do_pop;
  assign full_o  = (cnt_q == (AW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (AW+1)'(Depth)) else $error("queue count overflow");
  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_o && !pop_i) |=> full_o) else $error("full dropped without pop");
  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty_o && push_i) |=> !empty_o) else $error("push lost");
endmodule

// ===== design/sha_core.sv =====
// ----------------------------------------------------------------------------
// SHA-256 back end
// Buffers bytes, pads, runs one round per cycle and emits the digest words.
// ----------------------------------------------------------------------------
module sha_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sha_pkg::cmd_t cmd_i,
  input  logic          cmd_empty_i,
  output logic          cmd_pop_o,
  output logic [31:0]   digest_word_o,
  output logic [2:0]    word_index_o,
  output logic          last_word_o,
  output logic          empty_o,
  input  logic          pop_i
);
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StPad  = 3'd1;
  localparam logic [2:0] StRnd  = 3'd2;
  localparam logic [2:0] StAdd  = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  logic [2:0]  st_q;
  logic [5:0]  fill_q;
  logic [63:0] len_q;
  logic        fin_q;   // final block pending / in progress
  logic        pad_done_q; // 0x80 placed
  logic        xtra_q;  // 0x80 landed at 56..63, length goes in the next block
  sha_pkg::word_t h_q [8];
  sha_pkg::word_t v_q [8];
  sha_pkg::word_t w_q [16];
  logic [5:0]  rnd_q;
  logic [2:0]  oidx_q;

  logic take;
  assign take = (st_q == StIdle) && !cmd_empty_i;
  assign cmd_pop_o = take;

  assign empty_o = (st_q != StOut);
  assign digest_word_o = h_q[oidx_q];
  assign word_index_o  = oidx_q;
  assign last_word_o   = (oidx_q == 3'd7);

  // round logic; w_q[0] is W[t], w_q[15] takes W[t+16]
  sha_pkg::word_t wt, t1, t2, wnew;
  assign wt = w_q[0];
  assign wnew = w_q[0] + sha_pkg::sig0(w_q[1]) + w_q[9] + sha_pkg::sig1(w_q[14]);
  assign t1 = v_q[7] + sha_pkg::bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
            + sha_pkg::RoundK[rnd_q] + wt;
  assign t2 = sha_pkg::bsig0(v_q[0])
            + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

  // padding byte at current fill position
  logic [7:0] pad_byte;
  logic [7:0] len_byte;
  logic [63:0] bits;
  assign bits = {len_q[60:0], 3'b000};
  assign len_byte = bits[{3'd7 - fill_q[2:0], 3'b000} +: 8];
  always_comb begin
    if (!pad_done_q) begin
      pad_byte = sha_pkg::PadByte;
    end else if (fill_q >= sha_pkg::LenOffset && !xtra_q) begin
      pad_byte = len_byte;
    end else begin
      pad_byte = 8'h00;
    end
  end

  // bytes land straight in the schedule window, big-endian within a word
  always_ff @(posedge clk_i) begin
    if (st_q == StRnd) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wnew;
      v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end else begin
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
      if (st_q == StPad || (take && cmd_i.valid)) begin
        w_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <=
          (st_q == StPad) ? pad_byte : cmd_i.data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      fill_q <= '0;
      len_q <= '0;
      fin_q <= 1'b0;
      pad_done_q <= 1'b0;
      xtra_q <= 1'b0;
      rnd_q <= '0;
      oidx_q <= '0;
      for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::InitH[i];
    end else begin
      case (st_q)
        StIdle: begin
          if (take) begin
            if (cmd_i.valid) begin
              fill_q <= fill_q + 1'b1;
              len_q  <= len_q + 64'd1;
            end
            if (cmd_i.last) begin
              fin_q <= 1'b1;
              pad_done_q <= 1'b0;
              xtra_q <= 1'b0;
              st_q <= (cmd_i.valid && fill_q == 6'd63) ? StRnd : StPad;
            end else if (cmd_i.valid && fill_q == 6'd63) begin
              st_q <= StRnd;
            end
            rnd_q <= '0;
          end
        end
        StPad: begin
          pad_done_q <= 1'b1;
          if (!pad_done_q && fill_q >= sha_pkg::LenOffset) xtra_q <= 1'b1;
          fill_q <= fill_q + 1'b1;
          if (fill_q == 6'd63) begin
            st_q <= StRnd;
            rnd_q <= '0;
          end
        end
        StRnd: begin
          rnd_q <= rnd_q + 1'b1;
          if (rnd_q == 6'(sha_pkg::NumRounds - 1)) st_q <= StAdd;
        end
        StAdd: begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
          if (!fin_q) begin
            st_q <= StIdle;
          end else if (pad_done_q && !xtra_q) begin
            st_q <= StOut;
            oidx_q <= '0;
          end else begin
            st_q <= StPad;
            xtra_q <= 1'b0;
          end
        end
        StOut: begin
          if (pop_i) begin
            oidx_q <= oidx_q + 1'b1;
            if (oidx_q == 3'd7) begin
              st_q <= StIdle;
              fin_q <= 1'b0;
              len_q <= '0;
              fill_q <= '0;
              for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::InitH[i];
            end
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> (!empty_o && $stable(oidx_q))) else $error("output moved");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> st_q == StIdle) else $error("took while busy");
  a_rnd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(st_q == StRnd) |-> rnd_q == '0) else $error("round count");
endmodule

// ===== design/sha256_hash_engine.sv =====
// ----------------------------------------------------------------------------
// SHA-256 hash engine
// Byte-fed SHA-256; emits the 8-word digest after the last byte.
// ----------------------------------------------------------------------------
// Input: push with data_byte_i/byte_valid_i/last_byte_i, accepted when
// full is low. Items are stored in a 4-entry queue and the back end takes
// one per idle cycle. Every 64th byte stalls the back end while it runs the
// 64 rounds and the add. A last item pads the rest of the block byte by
// byte, then runs the rounds and the add; if 0x80 lands at offset 56 or
// later, a second padded block follows.
// Output: while empty is low the digest word at word_index_o is shown;
// pop takes it. Eight words, word 0 first, last_word_o on word 7.
// A stalled receiver holds the word and the back end; input continues
// until the queue fills. Reset loads the initial hash values and clears
// the length and fill count.
// ----------------------------------------------------------------------------
module sha256_hash_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_valid_i,
  input  logic        last_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);
  sha_pkg::cmd_t wcmd, rcmd;
  logic q_empty, q_pop;

  assign wcmd.data  = data_byte_i;
  assign wcmd.valid = byte_valid_i;
  assign wcmd.last  = last_byte_i;

  sha_queue #(.Depth(4)) u_queue (
    .clk_i, .rst_ni,
    .push_i(push), .wdata_i(wcmd), .full_o(full),
    .pop_i(q_pop), .rdata_o(rcmd), .empty_o(q_empty)
  );

  sha_core u_core (
    .clk_i, .rst_ni,
    .cmd_i(rcmd), .cmd_empty_i(q_empty), .cmd_pop_o(q_pop),
    .digest_word_o, .word_index_o, .last_word_o,
    .empty_o(empty), .pop_i(pop)
  );
endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-256 hash engine testbench
// Feeds byte items (directed table, pad boundaries, receiver hold-off, then
// random messages), predicts each digest with a behavioral SHA-256 and checks every popped word in order.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned RandItems  = 90;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_t;

  typedef struct {
    logic [7:0] data;
    logic       valid;
    logic       last;
    logic       chk;     // typed-in expectation for word 0 of the digest
    logic [31:0] word0;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  data_byte_i = '0;
  logic        byte_valid_i = 1'b0;
  logic        last_byte_i = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_word_o;

  sha256_hash_engine dut (
    .clk_i, .rst_ni, .push, .full, .data_byte_i, .byte_valid_i, .last_byte_i,
    .empty, .pop, .digest_word_o, .word_index_o, .last_word_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [31:0] hash_h [8];
  logic [7:0]  blk [64];
  int unsigned fill;
  logic [63:0] msg_len;
  digest_t     digest_q [$];
  int unsigned n_errors = 0;
  int unsigned cycles = 0;
  bit          hold_off = 1'b0;

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic run_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int t = 0; t < 16; t++)
      w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
    for (int t = 16; t < 64; t++)
      w[t] = w[t-16] + w[t-7]
           + (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3))
           + (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10));
    for (int i = 0; i < 8; i++) v[i] = hash_h[i];
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::RoundK[t] + w[t];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_h[i] += v[i];
  endtask

  task automatic hash_clear();
    for (int i = 0; i < 8; i++) hash_h[i] = sha_pkg::InitH[i];
    fill = 0;
    msg_len = '0;
  endtask

  task automatic hash_step(logic [7:0] b, logic vld, logic lst);
    logic [63:0] bits;
    if (vld) begin
      blk[fill] = b;
      fill++;
      msg_len++;
      if (fill == 64) begin
        run_block();
        fill = 0;
      end
    end
    if (lst) begin
      bits = msg_len << 3;
      blk[fill] = sha_pkg::PadByte;
      fill++;
      if (fill > 56) begin
        while (fill < 64) blk[fill++] = 8'h00;
        run_block();
        fill = 0;
      end
      while (fill < 56) blk[fill++] = 8'h00;
      for (int i = 0; i < 8; i++) blk[56+i] = bits[63-8*i -: 8];
      run_block();
      for (int i = 0; i < 8; i++)
        digest_q.push_back('{hash_h[i], 3'(i), i == 7});
      hash_clear();
    end
  endtask

  // drive one item; predict at acceptance
  task automatic send_item(logic [7:0] b, logic vld, logic lst);
    push <= 1'b1;
    data_byte_i <= b;
    byte_valid_i <= vld;
    last_byte_i <= lst;
    do @(posedge clk_i); while (full);
    hash_step(b, vld, lst);
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      push <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    do @(posedge clk_i); while (digest_q.size() != 0);
  endtask

  // receiver: pattern stalls plus a long hold-off on request
  initial begin
    int phase;
    phase = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      phase = (phase + 1) % 23;
      if (hold_off) pop <= 1'b0;
      else if (phase < 8) pop <= 1'b1;
      else pop <= ($urandom_range(0, 2) != 0);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    digest_t got, exp;
    if (rst_ni && pop && !empty) begin
      got = '{digest_word_o, word_index_o, last_word_o};
      if (digest_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected digest word %h idx %0d", got.word, got.idx);
      end else begin
        exp = digest_q.pop_front();
        if (got !== exp) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch: exp %h/%0d/%0b got %h/%0d/%0b", exp.word, exp.idx,
                     exp.last, got.word, got.idx, got.last);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  row_t dir_tab [$];

  initial begin
    int n_items, len;
    bit send_noise;
    hash_clear();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty message, known first digest word
    dir_tab.push_back('{8'h00, 1'b0, 1'b1, 1'b1, 32'he3b0c442});
    // "abc"
    dir_tab.push_back('{8'h61, 1'b1, 1'b0, 1'b0, 32'h0});
    dir_tab.push_back('{8'h62, 1'b1, 1'b0, 1'b0, 32'h0});
    dir_tab.push_back('{8'h63, 1'b1, 1'b1, 1'b1, 32'hba7816bf});
    // idle items change nothing; a last item with no byte ends 00 ff; one-byte ff, 00 follow
    dir_tab.push_back('{8'hff, 1'b0, 1'b0, 1'b0, 32'h0});
    dir_tab.push_back('{8'h00, 1'b1, 1'b0, 1'b0, 32'h0});
    dir_tab.push_back('{8'hff, 1'b1, 1'b0, 1'b0, 32'h0});
    dir_tab.push_back('{8'h5a, 1'b0, 1'b0, 1'b0, 32'h0});
    dir_tab.push_back('{8'ha5, 1'b0, 1'b1, 1'b0, 32'h0});
    dir_tab.push_back('{8'hff, 1'b1, 1'b1, 1'b0, 32'h0});
    dir_tab.push_back('{8'h00, 1'b1, 1'b1, 1'b0, 32'h0});

    foreach (dir_tab[i]) begin
      send_item(dir_tab[i].data, dir_tab[i].valid, dir_tab[i].last);
      if (dir_tab[i].chk && digest_q[digest_q.size()-8].word !== dir_tab[i].word0) begin
        n_errors++;
        $display("predictor mismatch on directed row %0d", i);
      end
      if ($urandom_range(0, 1)) idle_gap($urandom_range(0, 3));
    end
    wait_drained();

    // pad boundaries: lengths 55, 56, 63, 64
    for (int k = 0; k < 4; k++) begin
      len = (k == 0) ? 55 : (k == 1) ? 56 : (k == 2) ? 63 : 64;
      for (int j = 0; j < len; j++) send_item(8'($urandom), 1'b1, j == len - 1);
    end

    // long receiver hold-off while the sender keeps pushing
    hold_off = 1'b1;
    fork
      begin
        repeat (3) for (int j = 0; j < 5; j++) send_item(8'($urandom), 1'b1, j == 4);
      end
      begin
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
    join
    wait_drained();

    // random messages in bursts, mostly short, some long
    n_items = 0;
    while (n_items < RandItems) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 140) : $urandom_range(0, 20);
      for (int j = 0; j <= len; j++) begin
        send_noise = ($urandom_range(0, 9) == 0);
        if (send_noise) send_item(8'($urandom), 1'b0, 1'b0);
        if (j == len) send_item(8'($urandom), 1'($urandom_range(0, 1)), 1'b1);
        else begin
          send_item(8'($urandom), 1'b1, 1'b0);
          n_items++;
        end
        if ($urandom_range(0, 5) == 0) idle_gap($urandom_range(1, 12));
      end
      n_items++;
      if ($urandom_range(0, 9) == 0) wait_drained();
    end

    wait_drained();
    repeat (200) @(posedge clk_i);
    if (n_errors == 0 && digest_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sha256_hash_engine.f =====
design/sha_pkg.sv
design/sha_queue.sv
design/sha_core.sv
design/sha256_hash_engine.sv
bench/tb_top.sv
